// ===== rtl/nffla_pkg.sv =====
// Package for the next-fit free-list allocator: constants, codes, FSM state type.
// No dependencies.
package nffla_pkg;

  localparam int AddrW      = 16;
  localparam int SizeW      = 17;
  localparam int BytesW     = 19;
  localparam int UnitShift  = 3;
  localparam int PageShift  = 9;
  localparam logic [16:0] HeapUnits = 17'h10000;
  localparam logic [15:0] LimitReset = 16'hFFFF;
  localparam logic [15:0] GrowReset  = 16'd1024;
  localparam logic [18:0] WalkLimit  = 19'd131080;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC = 2'd0;
  localparam logic [1:0] ST_FREED = 2'd1;
  localparam logic [1:0] ST_FAIL  = 2'd2;

  localparam logic       REG_LIMIT = 1'b0;
  localparam logic       REG_GROW  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD0,   // read link[rover]
    S_A_RD1,   // read size[p]
    S_A_CHK,   // decide fit
    S_A_SPL,   // write split header
    S_A_NXT,   // not entered; the walk advances in S_A_CHK
    S_A_NXTW,
    S_G_CHK,   // grow check
    S_I_RD,    // insert: read link[p], size[p]
    S_I_CHK,
    S_I_RDN,   // read size/link of nx
    S_I_RDB,   // read size of bp
    S_I_W1,    // write bp header
    S_I_W2,    // write p header
    S_I_DONE,
    S_OUT
  } state_t;

endpackage

// ===== rtl/nffla_hdr_mem.sv =====
// Header memory: link (16b) and size (17b) per unit, one port, registered read.
// Depends on nffla_pkg.
module nffla_hdr_mem (
  input  logic                      clk,
  input  logic [nffla_pkg::AddrW-1:0] addr,
  input  logic                      we_link,
  input  logic                      we_size,
  input  logic [nffla_pkg::AddrW-1:0] wlink,
  input  logic [nffla_pkg::SizeW-1:0] wsize,
  output logic [nffla_pkg::AddrW-1:0] rlink,
  output logic [nffla_pkg::SizeW-1:0] rsize
);
  import nffla_pkg::*;

  logic [AddrW-1:0] link_mem [0:65535];
  logic [SizeW-1:0] size_mem [0:65535];

  always_ff @(posedge clk) begin
    if (we_link) begin
      link_mem[addr] <= wlink;
    end
    if (we_size) begin
      size_mem[addr] <= wsize;
    end
    rlink <= link_mem[addr];
    rsize <= size_mem[addr];
  end
endmodule

// ===== rtl/next_fit_free_list_allocator_top.sv =====
// Next-fit free-list allocator: a sequencer around one header memory.
// Allocate walks the free list from the rover, splits a block larger than needed, and
// grows the heap when a lap finds no fit; the growth is inserted like a free. Free walks
// the list to the insert point and merges the block with its neighbours.
// One request in flight; the next is taken only after the result has been accepted.
// Reset: rover 0, heap top 1, list not started; limit 65535, min grow 1024.
// Header memory contents are not cleared; the sentinel is written on first request.
// Depends on nffla_pkg, nffla_hdr_mem.
module next_fit_free_list_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [0] opcode, [19:1] byte_count, [35:20] block_addr
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [1:0] status, [17:2] payload_addr
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import nffla_pkg::*;

  state_t state_r, state_nxt;
  logic [15:0] limit_r, grow_r;
  logic [15:0] rover_r, rover_nxt;
  logic [16:0] top_r, top_nxt;
  logic        started_r, started_nxt;
  logic [16:0] nun_r, nun_nxt;
  logic [15:0] prev_r, prev_nxt, p_r, p_nxt, bp_r, bp_nxt, nx_r, nx_nxt;
  logic [16:0] szp_r, szp_nxt, szb_r, szb_nxt, szn_r, szn_nxt;
  logic [15:0] lnn_r, lnn_nxt;
  logic [18:0] steps_r, steps_nxt;
  logic        grown_r, grown_nxt;
  logic [16:0] gtop_r, gtop_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic [15:0] opa_r, opa_nxt;
  logic        ph_r, ph_nxt;

  logic [15:0] maddr;
  logic        we_l, we_s;
  logic [15:0] wl;
  logic [16:0] ws;
  logic [15:0] rl;
  logic [16:0] rs;

  nffla_hdr_mem u_mem (
    .clk(clk), .addr(maddr), .we_link(we_l), .we_size(we_s),
    .wlink(wl), .wsize(ws), .rlink(rl), .rsize(rs)
  );

  assign cfg_ready  = (state_r == S_IDLE);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, opa_r, ost_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LimitReset;
      grow_r  <= GrowReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LIMIT: limit_r <= cfg_data;
        REG_GROW:  grow_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rover_r   <= '0;
      top_r     <= 17'd1;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rover_r   <= rover_nxt;
      top_r     <= top_nxt;
      started_r <= started_nxt;
    end
    nun_r <= nun_nxt; prev_r <= prev_nxt; p_r <= p_nxt;
    bp_r <= bp_nxt; nx_r <= nx_nxt; szp_r <= szp_nxt; szb_r <= szb_nxt;
    szn_r <= szn_nxt; lnn_r <= lnn_nxt; steps_r <= steps_nxt;
    grown_r <= grown_nxt; gtop_r <= gtop_nxt;
    ost_r <= ost_nxt; opa_r <= opa_nxt; ph_r <= ph_nxt;
  end

  logic [19:0] bytes_rnd;
  logic [16:0] gmax, gpg, glim;
  logic [17:0] gsum;
  logic        ins_brk;
  logic [16:0] ins_sum_b, ins_sum_p, a_rem;

  always_comb begin
    bytes_rnd = {1'b0, in_tdata[19:1]} + 20'd7;
    gmax = (nun_r < {1'b0, grow_r}) ? {1'b0, grow_r} : nun_r;
    gpg  = (gmax + 17'd511) & ~17'd511;
    gsum = {1'b0, top_r} + {1'b0, gpg};
    glim = {1'b0, limit_r};
    ins_brk = ((bp_r > p_r) && (bp_r < rl)) ||
              ((p_r >= rl) && ((bp_r > p_r) || (bp_r < rl)));
    ins_sum_b = {1'b0, bp_r} + szb_r;
    ins_sum_p = {1'b0, p_r} + szp_r;
    a_rem = rs - nun_r;
  end

  always_comb begin
    state_nxt = state_r; rover_nxt = rover_r; top_nxt = top_r;
    started_nxt = started_r; nun_nxt = nun_r; prev_nxt = prev_r;
    p_nxt = p_r; bp_nxt = bp_r; nx_nxt = nx_r; szp_nxt = szp_r; szb_nxt = szb_r;
    szn_nxt = szn_r; lnn_nxt = lnn_r; steps_nxt = steps_r;
    grown_nxt = grown_r; gtop_nxt = gtop_r;
    ost_nxt = ost_r; opa_nxt = opa_r; ph_nxt = ph_r;
    maddr = p_r; we_l = 1'b0; we_s = 1'b0; wl = '0; ws = '0;
    unique case (state_r)
      S_IDLE: begin
        maddr = rover_r;
        if (in_tvalid) begin
          nun_nxt = bytes_rnd[19:3] + 17'd1;
          bp_nxt = in_tdata[35:20] - 16'd1;
          steps_nxt = '0;
          grown_nxt = 1'b0;
          if (!started_r) begin
            maddr = '0; we_l = 1'b1; we_s = 1'b1;
            started_nxt = 1'b1;
            rover_nxt = '0;
          end
          if (in_tdata[0] == OP_FREE) begin
            p_nxt = started_r ? rover_r : 16'd0;
            state_nxt = S_I_RD;
            ph_nxt = 1'b0;
          end else begin
            prev_nxt = started_r ? rover_r : 16'd0;
            state_nxt = S_A_RD0;
          end
        end
      end
      S_A_RD0: begin
        maddr = prev_r;
        state_nxt = S_A_NXTW;
      end
      S_A_NXTW: begin
        // rl holds link[prev]
        p_nxt = rl;
        state_nxt = S_A_RD1;
      end
      S_A_RD1: begin
        maddr = p_r;
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        maddr = prev_r;
        if (rs >= nun_r) begin
          rover_nxt = prev_r;
          ost_nxt = ST_ALLOC;
          if (rs == nun_r) begin
            we_l = 1'b1; wl = rl;
            opa_nxt = p_r + 16'd1;
            state_nxt = S_OUT;
          end else begin
            maddr = p_r; we_s = 1'b1; ws = a_rem;
            p_nxt = p_r + a_rem[15:0];
            state_nxt = S_A_SPL;
          end
        end else if (p_r == rover_r && !grown_r) begin
          state_nxt = S_G_CHK;
        end else begin
          grown_nxt = 1'b0;
          prev_nxt = p_r;
          p_nxt = rl;
          steps_nxt = steps_r + 19'd1;
          state_nxt = (steps_r + 19'd1 > WalkLimit) ? S_OUT : S_A_RD1;
          ost_nxt = ST_FAIL; opa_nxt = '0;
        end
      end
      S_A_SPL: begin
        maddr = p_r; we_s = 1'b1; ws = nun_r;
        opa_nxt = p_r + 16'd1;
        state_nxt = S_OUT;
      end
      S_G_CHK: begin
        if ({1'b0, gsum[16:0]} > {1'b0, glim} || gsum[17] || top_r[16]) begin
          ost_nxt = ST_FAIL; opa_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          gtop_nxt = gsum[16:0];
          bp_nxt = top_r[15:0];
          maddr = top_r[15:0]; we_s = 1'b1; ws = gpg;
          p_nxt = rover_r;
          ph_nxt = 1'b1;
          state_nxt = S_I_RD;
        end
      end
      S_I_RD: begin
        maddr = p_r;
        state_nxt = S_I_CHK;
      end
      S_I_CHK: begin
        szp_nxt = rs;
        if (ins_brk || steps_r + 19'd1 > WalkLimit) begin
          nx_nxt = rl;
          maddr = rl;
          state_nxt = S_I_RDN;
        end else begin
          steps_nxt = steps_r + 19'd1;
          p_nxt = rl;
          maddr = rl;
          state_nxt = S_I_CHK;
        end
      end
      S_I_RDN: begin
        szn_nxt = rs; lnn_nxt = rl;
        maddr = bp_r;
        state_nxt = S_I_RDB;
      end
      S_I_RDB: begin
        szb_nxt = rs;
        state_nxt = S_I_W1;
      end
      S_I_W1: begin
        maddr = bp_r; we_l = 1'b1; we_s = 1'b1;
        if (ins_sum_b == {1'b0, nx_r}) begin
          ws = szb_r + szn_r; wl = lnn_r;
          szb_nxt = szb_r + szn_r; lnn_nxt = lnn_r;
        end else begin
          ws = szb_r; wl = nx_r; lnn_nxt = nx_r;
        end
        state_nxt = S_I_W2;
      end
      S_I_W2: begin
        maddr = p_r; we_l = 1'b1;
        if (ins_sum_p == {1'b0, bp_r}) begin
          we_s = 1'b1; ws = szp_r + szb_r; wl = lnn_r;
        end else begin
          wl = bp_r;
        end
        rover_nxt = p_r;
        state_nxt = S_I_DONE;
      end
      S_I_DONE: begin
        if (ph_r) begin
          top_nxt = gtop_r;
          grown_nxt = 1'b1;
          prev_nxt = rover_r;
          p_nxt = rover_r;
          steps_nxt = steps_r + 19'd1;
          state_nxt = S_A_RD0;
          ph_nxt = 1'b0;
        end else begin
          ost_nxt = ST_FREED; opa_nxt = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && !out_tready |=> (state_r == S_OUT) && $stable(out_tdata))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[1:0] == ST_ALLOC || out_tdata[17:2] == 16'd0))
    else $error("nonzero address on free or fail");
endmodule
